[rtl/mpq_pkg.sv]
// Shared types and constants for the multilevel priority FIFO.
package mpq_pkg;

	localparam int LEVELS_DEF      = 16;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF = 16;

	// fixed port field widths
	localparam int PRI_W    = 4;
	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 9;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// decision for the request being taken this cycle
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} ctl_t;

endpackage

[rtl/mpq_ram.sv]
// Generic single-port RAM with registered read.
module mpq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/mpq_level_ctl.sv]
// Per-level head/tail/count table, level select and occupancy tracking.
module mpq_level_ctl #(
	parameter int LEVELS      = mpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  mpq_pkg::op_t                     op,
	input  logic [mpq_pkg::PRI_W-1:0]        pri,
	output mpq_pkg::ctl_t                    ctl,
	output logic [$clog2(LEVELS)-1:0]        lvl,
	output logic [$clog2(LEVEL_DEPTH)-1:0]   slot,
	output logic [mpq_pkg::COUNT_W-1:0]      total_after
);

	localparam int LVL_W = $clog2(LEVELS);
	localparam int PTR_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W = $clog2(LEVELS * LEVEL_DEPTH + 1);

	logic [PTR_W-1:0] head_q [LEVELS];
	logic [PTR_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] cnt_q  [LEVELS];
	logic [TOT_W-1:0] total_q;

	logic             found;
	logic [LVL_W-1:0] deq_lvl;
	logic [LVL_W-1:0] sel_lvl;
	logic             in_range;
	logic [CNT_W-1:0] sel_cnt;
	logic [PTR_W-1:0] sel_slot;
	logic [PTR_W-1:0] next_slot;
	logic             enq_ok;
	logic             deq_ok;
	logic [TOT_W-1:0] total_nxt;

	// priority encoder over non-empty levels, lowest index wins
	always_comb begin
		found   = 1'b0;
		deq_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				found   = 1'b1;
				deq_lvl = LVL_W'(i);
			end
		end
	end

	assign in_range  = 32'(pri) < 32'(LEVELS);
	assign sel_lvl   = (op == mpq_pkg::OP_DEQ) ? deq_lvl : LVL_W'(pri);
	assign sel_cnt   = cnt_q[sel_lvl];
	assign sel_slot  = (op == mpq_pkg::OP_DEQ) ? head_q[sel_lvl] : tail_q[sel_lvl];
	assign next_slot = (sel_slot == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : sel_slot + 1'b1;

	assign enq_ok = (op == mpq_pkg::OP_ENQ) && in_range
		&& (sel_cnt != CNT_W'(LEVEL_DEPTH));
	assign deq_ok = (op == mpq_pkg::OP_DEQ) && found;

	always_comb begin
		total_nxt = total_q;
		if (enq_ok) begin
			total_nxt = total_q + 1'b1;
		end else if (deq_ok) begin
			total_nxt = total_q - 1'b1;
		end
	end

	always_comb begin
		ctl.wr_en = req_valid && enq_ok;
		ctl.rd_en = req_valid && deq_ok;
		if (op == mpq_pkg::OP_DEQ) begin
			ctl.status = found ? mpq_pkg::ST_OK : mpq_pkg::ST_EMPTY;
		end else begin
			ctl.status = enq_ok ? mpq_pkg::ST_OK : mpq_pkg::ST_FULL;
		end
	end

	assign lvl         = sel_lvl;
	assign slot        = sel_slot;
	assign total_after = mpq_pkg::COUNT_W'(total_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			total_q <= '0;
		end else if (req_valid) begin
			if (enq_ok) begin
				tail_q[sel_lvl] <= next_slot;
				cnt_q[sel_lvl]  <= sel_cnt + 1'b1;
			end else if (deq_ok) begin
				head_q[sel_lvl] <= next_slot;
				cnt_q[sel_lvl]  <= sel_cnt - 1'b1;
			end
			total_q <= total_nxt;
		end
	end

endmodule

[rtl/multilevel_priority_fifo_unit.sv]
// Top level of the strict-priority multilevel FIFO.
//
//  channel   ports                                         handshake
//  request   operation, priority_req, item_handle          start && !busy
//  result    status, out_valid, out_handle, out_priority,  done (one cycle)
//            total_count
//
// One request per cycle while busy is low; its result appears with done in the cycle after acceptance,
// the delay being the registered read of the entry RAM.
// Level bookkeeping updates at the accepting edge, so the next request sees it at once.
// busy is high only during reset and the cycle after it; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
module multilevel_priority_fifo_unit #(
	parameter int LEVELS      = mpq_pkg::LEVELS_DEF,
	parameter int LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
	parameter int HANDLE_BITS = mpq_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [mpq_pkg::PRI_W-1:0]     priority_req,
	input  logic [mpq_pkg::HANDLE_W-1:0]  item_handle,
	output logic                          done,
	output logic [1:0]                    status,
	output logic                          out_valid,
	output logic [mpq_pkg::HANDLE_W-1:0]  out_handle,
	output logic [mpq_pkg::PRI_W-1:0]     out_priority,
	output logic [mpq_pkg::COUNT_W-1:0]   total_count
);

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	logic                         busy_q;
	logic                         accept;
	mpq_pkg::ctl_t                ctl;
	logic [LVL_W-1:0]             lvl;
	logic [PTR_W-1:0]             slot;
	logic [mpq_pkg::COUNT_W-1:0]  total_after;
	logic [ADDR_W-1:0]            addr;
	logic [HANDLE_BITS-1:0]       rdata;

	logic                         done_s1;
	mpq_pkg::status_t             status_s1;
	logic                         valid_s1;
	logic [mpq_pkg::PRI_W-1:0]    pri_s1;
	logic [mpq_pkg::COUNT_W-1:0]  total_s1;

	assign accept = start && !busy_q;

	mpq_level_ctl #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_level_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (accept),
		.op          (mpq_pkg::op_t'(operation)),
		.pri         (priority_req),
		.ctl         (ctl),
		.lvl         (lvl),
		.slot        (slot),
		.total_after (total_after)
	);

	// level-major layout: row per level, column per slot
	assign addr = ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot);

	mpq_ram #(
		.WIDTH (HANDLE_BITS),
		.DEPTH (DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.re    (ctl.rd_en),
		.addr  (addr),
		.wdata (HANDLE_BITS'(item_handle)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= ctl.status;
			valid_s1  <= ctl.rd_en;
			pri_s1    <= ctl.rd_en ? mpq_pkg::PRI_W'(lvl) : '0;
			total_s1  <= total_after;
		end
	end

	assign busy         = busy_q;
	assign done         = done_s1;
	assign status       = status_s1;
	assign out_valid    = valid_s1;
	assign out_handle   = valid_s1 ? mpq_pkg::HANDLE_W'(rdata) : '0;
	assign out_priority = pri_s1;
	assign total_count  = total_s1;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request accepted without a result on the next cycle");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without an accepted request");

	a_valid_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> (status == mpq_pkg::ST_OK))
		else $error("dequeued handle reported with non-ok status");

	a_empty_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == mpq_pkg::ST_EMPTY) |-> (total_count == '0 && !out_valid))
		else $error("empty dequeue reported with items held");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_valid) |-> (out_handle == '0 && out_priority == '0))
		else $error("non-dequeue result carries handle or level");

endmodule
